// ===== rtl/protobuf_field_encoder_macros.svh =====
// assertion macros shared by the protobuf field encoder rtl
// expects clk and rst_n to be visible where a macro is used
`ifndef PROTOBUF_FIELD_ENCODER_MACROS_SVH
`define PROTOBUF_FIELD_ENCODER_MACROS_SVH

`ifndef NO_ASSERTIONS

// property holds on every clock outside reset
`define PFE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition must never be seen outside reset
`define PFE_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define PFE_ASSERT(lbl, prop, msg)
`define PFE_NEVER(lbl, cond, msg)

`endif

`endif

// ===== rtl/pfe_pkg.sv =====
// shared types and constants of the protobuf field encoder
// no dependencies
`timescale 1ns / 1ps

package pfe_pkg;

  localparam int FIELD_W = 29;
  localparam int VALUE_W = 64;
  localparam int TAG_W   = FIELD_W + 3;

  localparam logic [1:0] FUNC_VARINT  = 2'd0;
  localparam logic [1:0] FUNC_FIXED32 = 2'd1;
  localparam logic [1:0] FUNC_LEN     = 2'd2;
  localparam logic [1:0] FUNC_UNUSED  = 2'd3;

  localparam logic [2:0] WIRE_VARINT  = 3'd0;
  localparam logic [2:0] WIRE_FIXED32 = 3'd5;
  localparam logic [2:0] WIRE_LEN     = 3'd2;

  localparam logic [1:0] FIXED_LAST_IDX = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TAG,
    ST_VAL
  } pfe_state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic emit_tag;
    logic emit_val;
  } pfe_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic slot_free;
    logic tag_more;
    logic val_done;
  } pfe_sts_t;

  function automatic logic [2:0] wire_type(input logic [1:0] func);
    logic [2:0] w;
    unique case (func)
      FUNC_FIXED32: w = WIRE_FIXED32;
      FUNC_LEN:     w = WIRE_LEN;
      default:      w = WIRE_VARINT;
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/pfe_datapath.sv =====
// shift registers for tag and value, fixed32 byte counter and output register
// depends on pfe_pkg and protobuf_field_encoder_macros.svh
`timescale 1ns / 1ps
`include "protobuf_field_encoder_macros.svh"

module pfe_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  pfe_pkg::pfe_cmd_t             cmd,
  output pfe_pkg::pfe_sts_t             sts,
  input  logic [pfe_pkg::FIELD_W-1:0]   in_field_number,
  input  logic [1:0]                    in_func,
  input  logic [pfe_pkg::VALUE_W-1:0]   in_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [7:0]                    out_byte,
  output logic                          out_last
);
  import pfe_pkg::*;

  logic [TAG_W-1:0]   tag_r,   tag_nxt;
  logic [VALUE_W-1:0] val_r,   val_nxt;
  logic               fixed_r, fixed_nxt;
  logic [1:0]         cnt_r,   cnt_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [7:0]         out_byte_r,  out_byte_nxt;
  logic               out_last_r,  out_last_nxt;
  logic               val_more;

  assign val_more      = |val_r[VALUE_W-1:7];
  assign sts.tag_more  = |tag_r[TAG_W-1:7];
  assign sts.val_done  = fixed_r ? (cnt_r == FIXED_LAST_IDX) : !val_more;
  assign sts.slot_free = !out_valid_r || out_ready;

  always_comb begin
    tag_nxt       = tag_r;
    val_nxt       = val_r;
    fixed_nxt     = fixed_r;
    cnt_nxt       = cnt_r;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (cmd.load) begin
      tag_nxt   = {in_field_number, wire_type(in_func)};
      val_nxt   = in_value;
      fixed_nxt = (in_func == FUNC_FIXED32);
      cnt_nxt   = 2'd0;
    end
    if (cmd.emit_tag) begin
      out_byte_nxt  = {sts.tag_more, tag_r[6:0]};
      out_last_nxt  = 1'b0;
      out_valid_nxt = 1'b1;
      tag_nxt       = tag_r >> 7;
    end
    if (cmd.emit_val) begin
      out_valid_nxt = 1'b1;
      out_last_nxt  = sts.val_done;
      if (fixed_r) begin
        out_byte_nxt = val_r[7:0];
        val_nxt      = val_r >> 8;
        cnt_nxt      = cnt_r + 2'd1;
      end else begin
        out_byte_nxt = {val_more, val_r[6:0]};
        val_nxt      = val_r >> 7;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tag_r      <= tag_nxt;
    val_r      <= val_nxt;
    fixed_r    <= fixed_nxt;
    cnt_r      <= cnt_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;

  // a new byte may only enter the output register when it is empty or draining
  `PFE_ASSERT(a_emit_slot, (cmd.emit_tag || cmd.emit_val) |-> (!out_valid_r || out_ready), "byte emitted over a held beat")
  // the tag and the value never go out in the same cycle
  `PFE_NEVER(a_emit_excl, cmd.emit_tag && cmd.emit_val, "tag and value emitted together")

endmodule

// ===== rtl/pfe_ctrl.sv =====
// sequencing state machine: accept, tag bytes, value bytes
// depends on pfe_pkg and protobuf_field_encoder_macros.svh
`timescale 1ns / 1ps
`include "protobuf_field_encoder_macros.svh"

module pfe_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [1:0]        in_func,
  output logic              in_ready,
  input  pfe_pkg::pfe_sts_t sts,
  output pfe_pkg::pfe_cmd_t cmd
);
  import pfe_pkg::*;

  pfe_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        // an unused kind is taken and dropped
        if (in_valid && (in_func != FUNC_UNUSED)) begin
          cmd.load  = 1'b1;
          state_nxt = ST_TAG;
        end
      end
      ST_TAG: begin
        if (sts.slot_free) begin
          cmd.emit_tag = 1'b1;
          if (!sts.tag_more) begin
            state_nxt = ST_VAL;
          end
        end
      end
      ST_VAL: begin
        if (sts.slot_free) begin
          cmd.emit_val = 1'b1;
          if (sts.val_done) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  `PFE_ASSERT(a_load_idle, cmd.load |-> (state_r == ST_IDLE && in_ready), "load outside idle")
  `PFE_ASSERT(a_last_done, (cmd.emit_val && sts.val_done) |=> (state_r == ST_IDLE), "no return to idle after final byte")
  `PFE_ASSERT(a_load_tag, cmd.load |=> (state_r == ST_TAG), "load not followed by tag")

endmodule

// ===== rtl/protobuf_field_encoder.sv =====
// top level of the protobuf field encoder: one field in, its wire bytes out
// depends on pfe_pkg, pfe_ctrl and pfe_datapath
`timescale 1ns / 1ps

// channel | ports                                      | direction
// in      | in_valid in_ready in_field_number in_func in_value | field to encode
// out     | out_valid out_ready out_byte out_last      | one wire byte per beat
//
// an item is taken, then one byte leaves per cycle unless the output stalls, set
// by the single byte-wide output register; the next item is taken only after
// the last byte. an item yields 2 to 15 bytes; one of the unused kind is taken
// and yields nothing. synchronous active-low reset clears the state machine and
// the output valid. a stalled output holds its beat and pauses the sequencer.

module protobuf_field_encoder (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [pfe_pkg::FIELD_W-1:0]   in_field_number,
  input  logic [1:0]                    in_func,
  input  logic [pfe_pkg::VALUE_W-1:0]   in_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [7:0]                    out_byte,
  output logic                          out_last
);
  import pfe_pkg::*;

  pfe_cmd_t cmd;
  pfe_sts_t sts;

  // sequencer: idle accepts, then tag varint, then the value bytes
  pfe_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_func  (in_func),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // tag and value shifters feeding the output register
  pfe_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_field_number (in_field_number),
    .in_func         (in_func),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .out_last        (out_last)
  );

endmodule

// ===== tb/tb.sv =====
// self-checking bench for protobuf_field_encoder: random and directed fields in,
// every wire byte checked against an in-bench varint/fixed32 encoder
// depends on pfe_pkg and the protobuf_field_encoder rtl
`timescale 1ns / 1ps

module tb;
  import pfe_pkg::*;

  // run shape
  localparam int RANDOM_FIELDS = 450;
  localparam int IDLE_LIMIT    = 2000;  // cycles with no beat on either side
  localparam int HOLD_AT       = 150;   // fields taken before the long output hold
  localparam int HOLD_CYCLES   = 300;
  localparam int DRAIN_CYCLES  = 40;    // longest field is 15 bytes, plenty of margin
  localparam int MAX_REPORTS   = 100;

  // one field offered on the input channel
  typedef struct {
    logic [FIELD_W-1:0] number;
    logic [1:0]         func;
    logic [VALUE_W-1:0] value;
  } field_item_t;

  // one byte expected on the output channel
  typedef struct {
    logic [7:0] data;
    logic       last;
  } wire_beat_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [FIELD_W-1:0] in_field_number = '0;
  logic [1:0]         in_func = FUNC_VARINT;
  logic [VALUE_W-1:0] in_value = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [7:0]         out_byte;
  logic               out_last;

  field_item_t fields_to_send[$];
  wire_beat_t  wire_bytes_due[$];

  int fields_taken = 0;
  int beats_seen = 0;
  int mismatch_count = 0;
  int idle_cycles = 0;
  int hold_left = 0;
  logic hold_done = 1'b0;
  logic hold_off;

  // pacing state, each owned by one process
  int send_gap = 0;
  int send_calm = 0;
  int stall_left = 0;
  int recv_calm = 0;

  protobuf_field_encoder i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_field_number (in_field_number),
    .in_func         (in_func),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .out_last        (out_last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // expected wire bytes
  // ---------------------------------------------------------------------------

  // varint: 7 bits per byte, low group first, 0x80 on all but the final byte
  function automatic void push_varint(input logic [63:0] v, input logic ends_field);
    logic [63:0] rest;
    rest = v;
    while (rest > 64'h7F) begin
      wire_bytes_due.push_back('{data: {1'b1, rest[6:0]}, last: 1'b0});
      rest = rest >> 7;
    end
    wire_bytes_due.push_back('{data: rest[7:0], last: ends_field});
  endfunction

  // queue up every byte one accepted field should put on the wire
  function automatic void encode_field(input logic [FIELD_W-1:0] number,
                                       input logic [1:0] func,
                                       input logic [VALUE_W-1:0] value);
    logic [2:0] wire_kind;
    int i;
    case (func)
      FUNC_VARINT:  wire_kind = WIRE_VARINT;
      FUNC_FIXED32: wire_kind = WIRE_FIXED32;
      FUNC_LEN:     wire_kind = WIRE_LEN;
      default:      return;  // unused kind: dropped without output
    endcase
    // tag is never the final byte, the value always follows
    push_varint({32'd0, number, wire_kind}, 1'b0);
    if (func == FUNC_FIXED32) begin
      // low word only, little endian; upper 32 bits are don't-care
      for (i = 0; i < 4; i++) begin
        wire_bytes_due.push_back('{data: value[8*i +: 8], last: (i == FIXED_LAST_IDX)});
      end
    end else begin
      push_varint(value, 1'b1);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (mismatch_count < MAX_REPORTS) begin
      $display("[%0t] beat %0d: %s got 0x%0h want 0x%0h", $realtime, beats_seen, what,
               got, want);
    end
    mismatch_count++;
  endtask

  task automatic check_beat(input logic [7:0] data, input logic last);
    wire_beat_t want;
    if (wire_bytes_due.size() == 0) begin
      report_mismatch("byte with nothing pending", {56'd0, data}, 64'd0);
    end else begin
      want = wire_bytes_due.pop_front();
      if (data !== want.data) report_mismatch("out_byte", {56'd0, data}, {56'd0, want.data});
      if (last !== want.last) report_mismatch("out_last", {63'd0, last}, {63'd0, want.last});
    end
    beats_seen++;
  endtask

  // ---------------------------------------------------------------------------
  // pacing: mostly short gaps, a few long ones, and now and then a calm
  // stretch with no gaps at all
  // ---------------------------------------------------------------------------

  function automatic int pick_gap(inout int calm_left);
    int r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      calm_left = $urandom_range(20, 60);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 8);
    return $urandom_range(15, 40);
  endfunction

  // ---------------------------------------------------------------------------
  // input driver: takes fields off the pending queue, holds each one until
  // the block accepts it, and records what it should produce on acceptance
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin : feed_fields
    field_item_t next_item;
    logic offer;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      offer = in_valid;
      if (in_valid && in_ready) begin
        encode_field(in_field_number, in_func, in_value);
        fields_taken <= fields_taken + 1;
        offer = 1'b0;
      end
      if (!offer) begin
        if (send_gap != 0) begin
          send_gap--;
        end else if (fields_to_send.size() != 0) begin
          next_item = fields_to_send.pop_front();
          in_field_number <= next_item.number;
          in_func         <= next_item.func;
          in_value        <= next_item.value;
          offer = 1'b1;
          // gap that follows this field once it is taken
          send_gap = pick_gap(send_calm);
        end
      end
      // single assignment per edge keeps valid steady across back-to-back fields
      in_valid <= offer;
    end
  end

  // ---------------------------------------------------------------------------
  // output monitor: checks every accepted beat and paces out_ready
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin : collect_bytes
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) check_beat(out_byte, out_last);
      if (hold_off) begin
        out_ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        stall_left = pick_gap(recv_calm);
      end
    end
  end

  // long receiver hold partway through: the sender keeps offering, so the
  // encoder has to fill up and drop in_ready
  assign hold_off = (hold_left != 0);

  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && fields_taken >= HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  // cycles since the last beat on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  // ---------------------------------------------------------------------------
  // stimulus and end of run
  // ---------------------------------------------------------------------------

  task automatic add_field(input logic [FIELD_W-1:0] number, input logic [1:0] func,
                           input logic [VALUE_W-1:0] value);
    fields_to_send.push_back('{number: number, func: func, value: value});
  endtask

  initial begin : main
    int useful;
    int r;
    logic [1:0] func;
    logic [FIELD_W-1:0] number;
    logic [VALUE_W-1:0] value;

    // directed: zero value, varint group edges, tag length edges
    add_field(29'd0, FUNC_VARINT, 64'd0);
    add_field(29'd1, FUNC_VARINT, 64'd127);
    add_field(29'd1, FUNC_VARINT, 64'd128);
    add_field(29'd15, FUNC_VARINT, 64'd16383);
    add_field(29'd16, FUNC_VARINT, 64'd16384);
    add_field(29'd2047, FUNC_LEN, 64'd300);
    add_field(29'd2048, FUNC_LEN, 64'd0);
    // longest field: widest tag plus a ten-byte varint
    add_field(29'h1FFF_FFFF, FUNC_VARINT, 64'hFFFF_FFFF_FFFF_FFFF);
    add_field(29'h1FFF_FFFF, FUNC_LEN, 64'hFFFF_FFFF_FFFF_FFFF);
    add_field(29'h1555_5555, FUNC_VARINT, 64'h5555_5555_5555_5555);
    add_field(29'h0AAA_AAAA, FUNC_VARINT, 64'hAAAA_AAAA_AAAA_AAAA);
    add_field(29'd3, FUNC_VARINT, 64'h8000_0000_0000_0000);
    // fixed32: upper word must be ignored
    add_field(29'd5, FUNC_FIXED32, 64'hDEAD_BEEF_1234_5678);
    add_field(29'd5, FUNC_FIXED32, 64'd0);
    add_field(29'h1FFF_FFFF, FUNC_FIXED32, 64'hFFFF_FFFF_FFFF_FFFF);
    add_field(29'd0, FUNC_FIXED32, 64'h0000_0000_3F80_0000);
    // unused kind, alone and between real fields
    add_field(29'd7, FUNC_UNUSED, 64'd1);
    add_field(29'd9, FUNC_LEN, 64'd1);
    add_field(29'h1FFF_FFFF, FUNC_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF);
    add_field(29'd0, FUNC_LEN, 64'h0000_0000_0000_7FFF);

    // random: mixed sizes so every varint length turns up
    useful = 0;
    while (useful < RANDOM_FIELDS) begin
      r = $urandom_range(0, 99);
      if (r < 4) func = FUNC_UNUSED;
      else if (r < 45) func = FUNC_VARINT;
      else if (r < 72) func = FUNC_FIXED32;
      else func = FUNC_LEN;
      number = FIELD_W'($urandom);
      number = number >> $urandom_range(0, FIELD_W - 1);
      value = {$urandom, $urandom};
      value = value >> $urandom_range(0, VALUE_W);
      add_field(number, func, value);
      if (func != FUNC_UNUSED) useful++;
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // drain: all fields taken and every byte seen, or the watchdog trips
    while ((fields_to_send.size() != 0 || in_valid || wire_bytes_due.size() != 0) &&
           idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
    end

    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Simulation FAILED");
    end else begin
      // catch any stray bytes after the last expected one
      repeat (DRAIN_CYCLES) @(posedge clk);
      if (mismatch_count == 0 && wire_bytes_due.size() == 0) begin
        $display("Simulation PASSED");
      end else begin
        $display("Simulation FAILED");
      end
    end
    $finish;
  end

endmodule
